[design/drpu_pkg.sv]
// Shared types and constants for the dead-reckoning position update core.
package drpu_pkg;

  localparam int DistW  = 24;
  localparam int PosW   = 32;
  localparam int HeadW  = 15;
  localparam int XyW    = 33;
  localparam int ZW     = 32;
  localparam int TrigW  = 32;
  localparam int ProdW  = DistW + TrigW;
  localparam int CfgIdxW = 2;
  localparam int AtanEntries = 24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartY = 2'd1;

  // Quadrant codes of the heading.
  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;
  localparam logic [1:0] Quad3 = 2'd3;

  // Heading units are 1/64 degree.
  localparam logic [HeadW-1:0] FullTurn     = 15'd23040;
  localparam logic [HeadW-1:0] QuarterTurn  = 15'd5760;
  localparam logic [HeadW-1:0] HalfTurn     = 15'd11520;
  localparam logic [HeadW-1:0] ThreeQuarter = 15'd17280;

  // Binary angle of a remainder r is floor((r * 2^23 + 22) / 45). Since
  // 2^23 = 45 * 186413 + 23 this equals r * 186413 + floor((23 r + 22) / 45),
  // and the small quotient is a reciprocal multiply by ceil(2^24 / 45).
  localparam logic [30:0] AngleMulHi = 31'd186413;
  localparam logic [17:0] AngleMulLo = 18'd23;
  localparam logic [17:0] AngleBias  = 18'd22;
  localparam logic [36:0] RecipQ24   = 37'd372828;

  localparam logic signed [XyW-1:0] GainQ30 = 33'sd652032874;
  localparam logic signed [XyW-1:0] OneQ30  = 33'sd1073741824;
  localparam logic signed [ProdW:0] HalfQ30 = 57'sd536870912;

  localparam logic [31:0] AtanTab [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic        [HeadW-1:0] heading;
    logic signed [DistW-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
  } out_item_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cordic_t;

endpackage

[design/drpu_angle.sv]
// Heading front end: wraps the heading, splits off the quadrant and forms the binary angle.
module drpu_angle (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [drpu_pkg::HeadW-1:0]  heading_i,
  output logic                        valid_o,
  output drpu_pkg::cordic_t           data_o,
  output logic [1:0]                  quad_o
);
  import drpu_pkg::*;

  logic [HeadW-1:0] h_wrap;
  logic [1:0]       quad;
  logic [12:0]      rem;
  logic [30:0]      p1_d, p1_q;
  logic [17:0]      m_d, m_q;
  logic [1:0]       quad1_q;
  logic             vld1_q;
  logic [36:0]      recip_prod;
  logic [12:0]      small_quot;
  cordic_t          data_d, data_q;
  logic [1:0]       quad_q;
  logic             vld2_q;

  always_comb begin
    h_wrap = (heading_i >= FullTurn) ? heading_i - FullTurn : heading_i;
    priority if (h_wrap < QuarterTurn) begin
      quad = Quad0;
      rem  = 13'(h_wrap);
    end else if (h_wrap < HalfTurn) begin
      quad = Quad1;
      rem  = 13'(h_wrap - QuarterTurn);
    end else if (h_wrap < ThreeQuarter) begin
      quad = Quad2;
      rem  = 13'(h_wrap - HalfTurn);
    end else begin
      quad = Quad3;
      rem  = 13'(h_wrap - ThreeQuarter);
    end
    p1_d = 31'(rem) * AngleMulHi;
    m_d  = 18'(rem) * AngleMulLo + AngleBias;
  end

  always_comb begin
    recip_prod = 37'(m_q) * RecipQ24;
    small_quot = recip_prod[36:24];
    data_d.x   = GainQ30;
    data_d.y   = '0;
    data_d.z   = signed'(32'(p1_q) + 32'(small_quot));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p1_q    <= p1_d;
      m_q     <= m_d;
      quad1_q <= quad;
    end
    if (vld1_q) begin
      data_q <= data_d;
      quad_q <= quad1_q;
    end
  end

  assign valid_o = vld2_q;
  assign data_o  = data_q;
  assign quad_o  = quad_q;

endmodule

[design/drpu_cordic_cell.sv]
// One CORDIC rotation cell with a fixed shift and arctangent, registered at its output.
module drpu_cordic_cell #(
  parameter int Step = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  drpu_pkg::cordic_t data_i,
  output logic              valid_o,
  output drpu_pkg::cordic_t data_o
);
  import drpu_pkg::*;

  localparam logic signed [ZW-1:0] StepAtan = signed'(AtanTab[Step]);

  logic signed [XyW-1:0] dx, dy;
  cordic_t               data_d, data_q;
  logic                  vld_q;

  always_comb begin
    dx = data_i.y >>> Step;
    dy = data_i.x >>> Step;
    // A non-negative residual angle rotates counterclockwise.
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - StepAtan;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + StepAtan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

[design/dead_reckoning_position_update_core.sv]
// Top level of the dead-reckoning position update core.
// Each accepted transaction carries a heading (1/64 degree, clockwise from +y) and a signed
// distance; the core adds distance*sin(heading) to x and distance*cos(heading) to y, saturates
// both to 32 bits and returns the new position. Sine and cosine come from a chain of
// CORDIC_STEPS rotation cells (capped at 24) that one angle walks through, one cell per cycle,
// behind the angle front end and followed by a registered multiply. One transaction is in
// flight at a time, so a new one is accepted only after the last result has left the multiply
// register; a result may wait in the output register while the next transaction is accepted.
// Writing start_x or start_y loads both coordinates from the two start registers; reset clears
// all of them to zero.
module dead_reckoning_position_update_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  drpu_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output drpu_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [drpu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [drpu_pkg::PosW-1:0]     cfg_data_i
);
  import drpu_pkg::*;

  localparam int NumCells = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

  logic                    busy_q;
  logic                    in_fire, cfg_fire, xfer;
  logic signed [DistW-1:0] dist_q;
  logic [1:0]              quad;
  logic [NumCells:0]       chain_vld;
  cordic_t                 chain_data [NumCells+1];

  logic [XyW-2:0]          cos_c, sin_c;
  logic signed [TrigW-1:0] cos_p, sin_p, sin_v, cos_v;
  logic signed [ProdW-1:0] prod_x_q, prod_y_q;
  logic                    prod_vld_q;

  logic signed [ProdW:0]   rnd_x, rnd_y;
  logic signed [PosW:0]    sum_x, sum_y;
  logic signed [PosW-1:0]  new_x, new_y;
  logic signed [PosW-1:0]  pos_x_q, pos_y_q, start_x_q, start_y_q;
  out_item_t               out_q;
  logic                    out_vld_q;

  assign in_ready_o  = !busy_q;
  assign in_fire     = in_valid_i && in_ready_o;
  // Register writes wait until no transaction is inside the core.
  assign cfg_ready_o = !busy_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign xfer        = prod_vld_q && (!out_vld_q || out_ready_i);

  drpu_angle u_angle (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_fire),
    .heading_i (in_data_i.heading),
    .valid_o   (chain_vld[0]),
    .data_o    (chain_data[0]),
    .quad_o    (quad)
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    drpu_cordic_cell #(
      .Step (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_vld[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // Clamp the chain output to the unit range and fold it into the heading's quadrant.
  always_comb begin
    if (chain_data[NumCells].x[XyW-1]) begin
      cos_c = '0;
    end else if (chain_data[NumCells].x > OneQ30) begin
      cos_c = OneQ30[XyW-2:0];
    end else begin
      cos_c = chain_data[NumCells].x[XyW-2:0];
    end
    if (chain_data[NumCells].y[XyW-1]) begin
      sin_c = '0;
    end else if (chain_data[NumCells].y > OneQ30) begin
      sin_c = OneQ30[XyW-2:0];
    end else begin
      sin_c = chain_data[NumCells].y[XyW-2:0];
    end
    cos_p = signed'(TrigW'(cos_c));
    sin_p = signed'(TrigW'(sin_c));
    unique case (quad)
      Quad0: begin
        sin_v = sin_p;
        cos_v = cos_p;
      end
      Quad1: begin
        sin_v = cos_p;
        cos_v = -sin_p;
      end
      Quad2: begin
        sin_v = -sin_p;
        cos_v = -cos_p;
      end
      default: begin
        sin_v = -cos_p;
        cos_v = sin_p;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dist_q <= in_data_i.distance;
    end
    if (chain_vld[NumCells]) begin
      prod_x_q <= ProdW'(dist_q) * ProdW'(sin_v);
      prod_y_q <= ProdW'(dist_q) * ProdW'(cos_v);
    end
    if (xfer) begin
      out_q.pos_x <= new_x;
      out_q.pos_y <= new_y;
    end
  end

  // Round the Q30 change to nearest, add it to the position and saturate.
  always_comb begin
    rnd_x = (ProdW+1)'(prod_x_q) + HalfQ30;
    rnd_y = (ProdW+1)'(prod_y_q) + HalfQ30;
    sum_x = (PosW+1)'(pos_x_q) + (PosW+1)'(signed'(rnd_x[ProdW:30]));
    sum_y = (PosW+1)'(pos_y_q) + (PosW+1)'(signed'(rnd_y[ProdW:30]));
    if (sum_x[PosW] != sum_x[PosW-1]) begin
      new_x = {sum_x[PosW], {(PosW-1){!sum_x[PosW]}}};
    end else begin
      new_x = sum_x[PosW-1:0];
    end
    if (sum_y[PosW] != sum_y[PosW-1]) begin
      new_y = {sum_y[PosW], {(PosW-1){!sum_y[PosW]}}};
    end else begin
      new_y = sum_y[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      pos_x_q    <= '0;
      pos_y_q    <= '0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (xfer) begin
        busy_q <= 1'b0;
      end

      if (chain_vld[NumCells]) begin
        prod_vld_q <= 1'b1;
      end else if (xfer) begin
        prod_vld_q <= 1'b0;
      end

      if (xfer) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      priority if (xfer) begin
        pos_x_q <= new_x;
        pos_y_q <= new_y;
      end else if (cfg_fire && cfg_index_i == CfgStartX) begin
        start_x_q <= signed'(cfg_data_i);
        pos_x_q   <= signed'(cfg_data_i);
        pos_y_q   <= start_y_q;
      end else if (cfg_fire && cfg_index_i == CfgStartY) begin
        start_y_q <= signed'(cfg_data_i);
        pos_x_q   <= start_x_q;
        pos_y_q   <= signed'(cfg_data_i);
      end else begin
        pos_x_q <= pos_x_q;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_fire_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q)
    else $error("accepted transaction did not mark the core busy");

  a_xfer_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> (!busy_q && out_valid_o))
    else $error("result handoff did not free the core");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({chain_vld, prod_vld_q}))
    else $error("more than one transaction inside the cell chain");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (!prod_vld_q && chain_vld == '0))
    else $error("cell chain active while the core is idle");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the dead-reckoning position update core.
`timescale 1ns / 100ps

module testbench;
  import drpu_pkg::*;

  localparam int CordicSteps  = 16;
  localparam int SettleCycles = CordicSteps + 8;
  localparam int StallLimit   = 4000;

  // Indexes past the register list; writes to them must leave the position alone.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam longint CordicGain = 64'sd652032874;
  localparam longint UnitQ30    = 64'sd1073741824;
  localparam longint RoundHalf  = 64'sd536870912;
  localparam longint PosMax     = 64'sd2147483647;
  localparam longint PosMin     = -64'sd2147483648;

  localparam longint ArcTanTable [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
    'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
    'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
    'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [PosW-1:0]      cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Predicted block state.
  longint start_x_reg = 0;
  longint start_y_reg = 0;
  longint track_x = 0;
  longint track_y = 0;

  out_item_t expected_positions[$];

  dead_reckoning_position_update_core #(
    .CORDIC_STEPS(CordicSteps)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // Moves the tracked position by one odometry sample and returns the new position.
  function automatic out_item_t advance_position(in_item_t item);
    int unsigned hdg;
    int unsigned rem;
    logic [1:0]  quad;
    longint      cx;
    longint      sy;
    longint      ang;
    longint      step_x;
    longint      step_y;
    longint      sin_v;
    longint      cos_v;
    longint      travel;
    longint      sum;
    out_item_t   res;
    hdg = item.heading;
    if (hdg >= FullTurn) hdg -= FullTurn;
    quad = 2'(hdg / QuarterTurn);
    rem = hdg - (hdg / QuarterTurn) * QuarterTurn;
    cx = CordicGain;
    sy = 0;
    ang = ((longint'(rem) << 23) + 22) / 45;
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      step_x = sy >>> i;
      step_y = cx >>> i;
      if (ang >= 0) begin
        cx -= step_x;
        sy += step_y;
        ang -= ArcTanTable[i];
      end else begin
        cx += step_x;
        sy -= step_y;
        ang += ArcTanTable[i];
      end
    end
    if (cx < 0) cx = 0;
    if (cx > UnitQ30) cx = UnitQ30;
    if (sy < 0) sy = 0;
    if (sy > UnitQ30) sy = UnitQ30;
    case (quad)
      Quad0: begin
        sin_v = sy;
        cos_v = cx;
      end
      Quad1: begin
        sin_v = cx;
        cos_v = -sy;
      end
      Quad2: begin
        sin_v = -sy;
        cos_v = -cx;
      end
      default: begin
        sin_v = -cx;
        cos_v = sy;
      end
    endcase
    travel = longint'($signed(item.distance));
    sum = track_x + ((travel * sin_v + RoundHalf) >>> 30);
    track_x = (sum > PosMax) ? PosMax : (sum < PosMin) ? PosMin : sum;
    sum = track_y + ((travel * cos_v + RoundHalf) >>> 30);
    track_y = (sum > PosMax) ? PosMax : (sum < PosMin) ? PosMin : sum;
    res.pos_x = track_x[31:0];
    res.pos_y = track_y[31:0];
    return res;
  endfunction

  // Valid stays high after acceptance; the next call or settle() decides what follows.
  task automatic send_item(input int heading, input int distance);
    in_item_t item;
    item.heading = heading[HeadW-1:0];
    item.distance = distance[DistW-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    expected_positions.push_back(advance_position(item));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] value,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgStartX || idx == CfgStartY) begin
      if (idx == CfgStartX) start_x_reg = longint'($signed(value));
      else start_y_reg = longint'($signed(value));
      track_x = start_x_reg;
      track_y = start_y_reg;
    end
    if (last) cfg_valid <= 1'b0;
  endtask

  // Lets every outstanding result drain, then gives the pipeline time to go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_quadrant_sweep();
    send_item(0, 8388607);
    send_item(0, -8388608);
    send_item(5760, 8388607);
    send_item(11520, 8388607);
    send_item(17280, 8388607);
    send_item(23039, 8388607);
    send_item(5759, -8388608);
    send_item(2880, 256);
    send_item(1, 1);
    send_item(23040, 1000);
    send_item(32767, -1000);
    send_item(28800, 8388607);
    send_item(4000, 0);
    send_item(11519, -1);
    send_item(17279, 8388607);
    send_item(960, -8388608);
    settle();
  endtask

  task automatic test_start_and_saturation();
    write_reg(CfgStartX, 32'h7FFF_FF00, 1'b0);
    write_reg(CfgStartY, 32'h8000_0100, 1'b1);
    send_item(5760, 8388607);
    send_item(11520, 8388607);
    send_item(17280, 8388607);
    send_item(0, -8388608);
    settle();
    // Spare indexes are dropped without reloading the position.
    write_reg(CfgSpareA, 32'h1234_5678, 1'b0);
    write_reg(CfgSpareB, 32'hFFFF_FFFF, 1'b1);
    send_item(2880, 1000);
    settle();
    write_reg(CfgStartX, 32'h8000_0000, 1'b0);
    write_reg(CfgStartY, 32'h7FFF_FFFF, 1'b1);
    send_item(17280, 8388607);
    send_item(0, 8388607);
    settle();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count,
                                     input logic [PosW-1:0] sx, input logic [PosW-1:0] sy);
    int heading;
    int distance;
    write_reg(CfgStartX, sx, 1'b0);
    write_reg(CfgSpareA, $urandom, 1'b0);
    write_reg(CfgStartY, sy, 1'b1);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      case ($urandom_range(9))
        0: heading = $urandom_range(32767, 23040);
        1: heading = $urandom_range(3) * QuarterTurn + $urandom_range(1) * (QuarterTurn - 1);
        default: heading = $urandom_range(23039, 0);
      endcase
      case ($urandom_range(9))
        0: distance = $urandom_range(1) ? 8388607 : -8388608;
        1, 2: distance = int'($urandom_range(511)) - 256;
        default: distance = $urandom;
      endcase
      send_item(heading, distance);
    end
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, out_data.pos_x, out_data.pos_y);
        mismatch_count++;
      end else begin
        want = expected_positions.pop_front();
        if (out_data.pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, out_data.pos_x);
          mismatch_count++;
        end
        if (out_data.pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, out_data.pos_y);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_quadrant_sweep();
    test_start_and_saturation();
    test_random_traffic(0, 0, 400, $urandom, $urandom);
    test_random_traffic(63, 0, 400, 32'h7FFF_FFFF, 32'h8000_0000);
    test_random_traffic(0, 63, 400, 32'h8000_0000, 32'h7FFF_FFFF);
    test_random_traffic(12, 12, 400, 32'h0000_0000, 32'h0000_0000);
    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/drpu_pkg.sv
design/drpu_angle.sv
design/drpu_cordic_cell.sv
design/dead_reckoning_position_update_core.sv
tb/testbench.sv
